// File: design/isc_pkg.sv
// Shared types, codes and widths of the interval sweep collider.
package isc_pkg;

  localparam int unsigned PosBits      = 32;
  localparam int unsigned CalcBits     = PosBits + 11;
  localparam int unsigned SlotsDefault = 16;

  typedef enum logic [2:0] {
    REQ_WRITE     = 3'd0,
    REQ_CLEAR     = 3'd1,
    REQ_MOVE_KIN  = 3'd2,
    REQ_MOVE_AREA = 3'd3,
    REQ_QUERY     = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    KIND_STATIC    = 2'd0,
    KIND_KINEMATIC = 2'd1,
    KIND_AREA      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    EVT_OVERLAP = 2'd0,
    EVT_ENTERED = 2'd1,
    EVT_EXITED  = 2'd2,
    EVT_DONE    = 2'd3
  } evt_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         slot;
    logic [1:0]         entry_kind;
    logic signed [31:0] entry_position;
    logic [30:0]        entry_size;
    logic signed [31:0] movement;
    logic [15:0]        move_scale;
  } req_t;

  typedef struct packed {
    logic [1:0]                event_kind;
    logic [3:0]                subject_slot;
    logic [3:0]                other_slot;
    logic [1:0]                other_kind;
    logic signed [PosBits-1:0] new_position;
    logic signed [31:0]        remainder;
    logic                      last;
  } rsp_t;

  // Bounds of the mover: start interval, sweep and end interval.
  typedef struct packed {
    logic signed [CalcBits-1:0] pos;
    logic signed [CalcBits-1:0] h;
    logic signed [CalcBits-1:0] sl;
    logic signed [CalcBits-1:0] sr;
    logic signed [CalcBits-1:0] wl;
    logic signed [CalcBits-1:0] wr;
    logic signed [CalcBits-1:0] el;
    logic signed [CalcBits-1:0] er;
  } bnd_t;

  typedef struct packed {
    logic ov_w;
    logic ov_s;
    logic ov_e;
    logic right;
  } olap_t;

  typedef struct packed {
    logic wr_entry;
    logic wr_pos;
    logic clr;
  } tbl_ctl_t;

endpackage

// File: design/isc_table.sv
// Interval table: valid bits, kinds, positions and sizes with one read port.
module isc_table #(
  parameter int unsigned TableSlots = isc_pkg::SlotsDefault,
  localparam int unsigned IdxBits = (TableSlots > 1) ? $clog2(TableSlots) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  isc_pkg::tbl_ctl_t                 ctl_i,
  input  logic [IdxBits-1:0]                waddr_i,
  input  logic [1:0]                        wkind_i,
  input  logic signed [isc_pkg::PosBits-1:0] wpos_i,
  input  logic [30:0]                       wsize_i,
  input  logic [IdxBits-1:0]                raddr_i,
  output logic                              rd_valid_o,
  output logic [1:0]                        rd_kind_o,
  output logic signed [isc_pkg::PosBits-1:0] rd_pos_o,
  output logic [30:0]                       rd_size_o
);

  logic [TableSlots-1:0]             valid_q;
  logic [1:0]                        kind_q [TableSlots];
  logic signed [isc_pkg::PosBits-1:0] pos_q [TableSlots];
  logic [30:0]                       size_q [TableSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr_entry) begin
      valid_q[waddr_i] <= 1'b1;
    end else if (ctl_i.clr) begin
      valid_q[waddr_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_entry) begin
      kind_q[waddr_i] <= wkind_i;
      size_q[waddr_i] <= wsize_i;
    end
    if (ctl_i.wr_entry || ctl_i.wr_pos) begin
      pos_q[waddr_i] <= wpos_i;
    end
  end

  assign rd_valid_o = valid_q[raddr_i];
  assign rd_kind_o  = kind_q[raddr_i];
  assign rd_pos_o   = pos_q[raddr_i];
  assign rd_size_o  = size_q[raddr_i];

endmodule

// File: design/isc_olap.sv
// Shared overlap and clamp unit: tests one table entry against the mover's bounds.
module isc_olap (
  input  logic signed [isc_pkg::CalcBits-1:0] o_pos_i,
  input  logic [30:0]                         o_size_i,
  input  isc_pkg::bnd_t                       bnd_i,
  output isc_pkg::olap_t                      res_o,
  output logic signed [isc_pkg::CalcBits-1:0] fp_o
);

  logic signed [isc_pkg::CalcBits-1:0] oh;
  logic signed [isc_pkg::CalcBits-1:0] ol;
  logic signed [isc_pkg::CalcBits-1:0] orr;

  always_comb begin
    oh  = isc_pkg::CalcBits'({1'b0, o_size_i[30:1]});
    ol  = o_pos_i - oh;
    orr = o_pos_i + oh;
    res_o.ov_w  = (bnd_i.wl < orr) && (ol < bnd_i.wr);
    res_o.ov_s  = (bnd_i.sl < orr) && (ol < bnd_i.sr);
    res_o.ov_e  = (bnd_i.el < orr) && (ol < bnd_i.er);
    res_o.right = bnd_i.pos < o_pos_i;
    fp_o = res_o.right ? (ol - bnd_i.h) : (orr + bnd_i.h);
  end

endmodule

// File: design/interval_sweep_collider.sv
// Top level of the interval sweep collider: request sequencer and result buffering.
//
// The block keeps a table of one-dimensional intervals (static, kinematic or area).
// Requests arrive on the input channel (in_valid_i / in_stall_o, payload in_req_i);
// results leave on the output channel (out_valid_o / out_stall_i, payload out_rsp_o).
// A transfer happens at a rising edge where valid is high and stall is low.
// Writes and clears finish in the cycle of their transfer and give no results.
// A query scans all 3 * TABLE_SLOTS kind and slot pairs, one per cycle unless the
// output stalls. A kinematic move makes one clamp pass over the static and kinematic
// groups, then one pass over the area group for events. An area move has no clamp
// pass and makes its event pass over the static, kinematic and area groups.
// The scan rate is set by the single table read port and the one shared overlap
// unit, which handle one slot per cycle unless the output stalls. A crossing that
// enters and exits an entry gives two records, entered then exited. The input is
// stalled until the last record of the current request has been handed to the output
// register. Each record is held back one step so that the final one can carry last.
// When the receiver stalls, the output register holds its record and the scan
// waits as soon as a further record is ready; nothing is lost or repeated.
// Reset clears all valid bits of the table and empties the output.
module interval_sweep_collider #(
  parameter int unsigned TABLE_SLOTS = isc_pkg::SlotsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  isc_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output isc_pkg::rsp_t out_rsp_o
);

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned WB = isc_pkg::CalcBits;
  localparam int unsigned PB = isc_pkg::PosBits;
  localparam logic signed [WB-1:0] PMax = WB'((64'sd1 <<< (PB - 1)) - 64'sd1);
  localparam logic signed [WB-1:0] PMin = WB'(-(64'sd1 <<< (PB - 1)));
  localparam logic signed [WB-1:0] RMax = WB'(64'sd2147483647);
  localparam logic signed [WB-1:0] RMin = WB'(-64'sd2147483648);
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_BND, S_SCAN, S_SAT, S_DONE, S_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    M_QUERY, M_CLAMP, M_EVENT
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic                 kin_q, kin_d;
  logic [IW-1:0]        s_q, s_d;
  logic [3:0]           slot4_q, slot4_d;
  logic signed [31:0]   mv_q, mv_d;
  logic [15:0]          scale_q, scale_d;
  logic [47:0]          prod_q, prod_d;
  isc_pkg::bnd_t        bnd_q, bnd_d;
  logic signed [WB-1:0] np_q, np_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [1:0]           grp_q, grp_d;
  logic                 second_q, second_d;
  isc_pkg::rsp_t        hold_q, hold_d, out_q, out_d, rec;
  logic                 hold_valid_q, hold_valid_d, out_valid_q, out_valid_d;

  isc_pkg::tbl_ctl_t    tctl;
  logic [IW-1:0]        waddr, raddr;
  logic signed [PB-1:0] wpos;
  logic                 rd_valid;
  logic [1:0]           rd_kind;
  logic signed [PB-1:0] rd_pos;
  logic [30:0]          rd_size;
  isc_pkg::olap_t       ol_res;
  logic signed [WB-1:0] fp;

  logic                 accept, in_range, out_free, can_gen, gen, match;
  logic signed [WB-1:0] ext_pos, gm, np_sat, diff;
  logic [31:0]          mag;
  logic [39:0]          gmag;
  logic [1:0]           grp_end;

  isc_table #(.TableSlots(TABLE_SLOTS)) u_table (
    .clk_i, .rst_ni, .ctl_i(tctl), .waddr_i(waddr), .wkind_i(in_req_i.entry_kind),
    .wpos_i(wpos), .wsize_i(in_req_i.entry_size), .raddr_i(raddr),
    .rd_valid_o(rd_valid), .rd_kind_o(rd_kind), .rd_pos_o(rd_pos), .rd_size_o(rd_size)
  );

  isc_olap u_olap (
    .o_pos_i({{(WB-PB){rd_pos[PB-1]}}, rd_pos}), .o_size_i(rd_size), .bnd_i(bnd_q),
    .res_o(ol_res), .fp_o(fp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_range    = ({2'b00, in_req_i.slot} < 6'(TABLE_SLOTS));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign can_gen     = !hold_valid_q || out_free;
  assign raddr       = (state_q == S_IDLE) ? IW'(in_req_i.slot) : idx_q;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    // Arithmetic helpers.
    ext_pos = {{(WB-PB){rd_pos[PB-1]}}, rd_pos};
    mag     = mv_q[31] ? (~mv_q + 32'd1) : mv_q;
    gmag    = prod_q[47:8];
    gm      = mv_q[31] ? -WB'(gmag) : WB'(gmag);
    if (np_q > PMax) begin
      np_sat = PMax;
    end else if (np_q < PMin) begin
      np_sat = PMin;
    end else begin
      np_sat = np_q;
    end
    diff    = bnd_q.pos + {{(WB-32){mv_q[31]}}, mv_q} - np_q;
    match   = rd_valid && (rd_kind == grp_q) && (idx_q != s_q);
    grp_end = (mode_q == M_CLAMP) ? 2'(isc_pkg::KIND_KINEMATIC)
                                  : 2'(isc_pkg::KIND_AREA);

    state_d = state_q; mode_d = mode_q; kin_d = kin_q; s_d = s_q; slot4_d = slot4_q;
    mv_d = mv_q; scale_d = scale_q; prod_d = prod_q; bnd_d = bnd_q; np_d = np_q;
    idx_d = idx_q; grp_d = grp_q; second_d = second_q;
    hold_d = hold_q; hold_valid_d = hold_valid_q;
    out_d = out_q; out_valid_d = out_valid_q && out_stall_i;
    tctl = '0; waddr = s_q; wpos = np_sat[PB-1:0];

    rec = '0;
    rec.subject_slot = slot4_q;
    rec.other_slot   = 4'(idx_q);
    rec.other_kind   = rd_kind;
    gen = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && in_range) begin
          waddr   = IW'(in_req_i.slot);
          s_d     = IW'(in_req_i.slot);
          slot4_d = in_req_i.slot;
          mv_d    = in_req_i.movement;
          scale_d = in_req_i.move_scale;
          bnd_d.pos = ext_pos;
          bnd_d.h   = WB'({1'b0, rd_size[30:1]});
          bnd_d.sl  = ext_pos - WB'({1'b0, rd_size[30:1]});
          bnd_d.sr  = ext_pos + WB'({1'b0, rd_size[30:1]});
          idx_d = '0; grp_d = '0; second_d = 1'b0;
          wpos = in_req_i.entry_position[PB-1:0];
          unique case (in_req_i.req_type)
            isc_pkg::REQ_WRITE: begin
              tctl.wr_entry = (in_req_i.entry_kind != 2'd3);
            end
            isc_pkg::REQ_CLEAR: begin
              tctl.clr = 1'b1;
            end
            isc_pkg::REQ_MOVE_KIN: begin
              kin_d = 1'b1;
              if (rd_valid && rd_kind == 2'(isc_pkg::KIND_KINEMATIC)) state_d = S_MUL;
            end
            isc_pkg::REQ_MOVE_AREA: begin
              kin_d = 1'b0;
              if (rd_valid && rd_kind == 2'(isc_pkg::KIND_AREA)) state_d = S_MUL;
            end
            isc_pkg::REQ_QUERY: begin
              kin_d = 1'b0;
              mode_d = M_QUERY;
              if (rd_valid) state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_d  = 48'(mag) * 48'(scale_q);
        state_d = S_BND;
      end
      S_BND: begin
        bnd_d.wl = gm[WB-1] ? bnd_q.sl + gm : bnd_q.sl;
        bnd_d.wr = gm[WB-1] ? bnd_q.sr : bnd_q.sr + gm;
        np_d     = bnd_q.pos + gm;
        mode_d   = M_CLAMP;
        state_d  = kin_q ? S_SCAN : S_SAT;
      end
      S_SCAN: begin
        if (mode_q == M_QUERY) begin
          gen = match && ol_res.ov_s;
          rec.event_kind = isc_pkg::EVT_OVERLAP;
        end else if (mode_q == M_EVENT) begin
          if (second_q) begin
            gen = 1'b1;
            rec.event_kind = isc_pkg::EVT_EXITED;
          end else begin
            gen = match && ol_res.ov_w && !(ol_res.ov_s && ol_res.ov_e);
            rec.event_kind = ol_res.ov_s ? isc_pkg::EVT_EXITED : isc_pkg::EVT_ENTERED;
          end
        end else if (match && ol_res.ov_w) begin
          if (ol_res.right ? (fp < np_q) : (fp > np_q)) np_d = fp;
        end
        if (!gen || can_gen) begin
          if (gen && mode_q == M_EVENT && !second_q && !ol_res.ov_s && !ol_res.ov_e) begin
            second_d = 1'b1;
          end else begin
            second_d = 1'b0;
            if (idx_q == LastIdx) begin
              idx_d = '0;
              grp_d = grp_q + 2'd1;
              if (grp_q == grp_end) begin
                if (mode_q == M_CLAMP) state_d = S_SAT;
                else if (mode_q == M_EVENT && kin_q) state_d = S_DONE;
                else state_d = S_FLUSH;
              end
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
        end
      end
      S_SAT: begin
        tctl.wr_pos = 1'b1;
        np_d     = np_sat;
        bnd_d.el = np_sat - bnd_q.h;
        bnd_d.er = np_sat + bnd_q.h;
        mode_d   = M_EVENT;
        idx_d    = '0;
        grp_d    = kin_q ? 2'(isc_pkg::KIND_AREA) : 2'(isc_pkg::KIND_STATIC);
        state_d  = S_SCAN;
      end
      S_DONE: begin
        rec.event_kind   = isc_pkg::EVT_DONE;
        rec.other_slot   = '0;
        rec.other_kind   = '0;
        rec.new_position = np_q[PB-1:0];
        rec.remainder    = (diff > RMax) ? 32'sh7fffffff :
                           (diff < RMin) ? 32'sh80000000 : diff[31:0];
        gen = 1'b1;
        if (can_gen) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!hold_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d = hold_q;
          out_d.last = 1'b1;
          out_valid_d = 1'b1;
          hold_valid_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // A new record pushes the held one out and takes its place.
    if (gen && can_gen) begin
      if (hold_valid_q) begin
        out_d = hold_q;
        out_valid_d = 1'b1;
      end
      hold_d = rec;
      hold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mode_q <= M_QUERY; kin_q <= 1'b0; s_q <= '0; slot4_q <= '0;
      mv_q <= '0; scale_q <= '0; prod_q <= '0; bnd_q <= '0; np_q <= '0;
      idx_q <= '0; grp_q <= '0; second_q <= 1'b0;
      hold_q <= '0; hold_valid_q <= 1'b0; out_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; mode_q <= mode_d; kin_q <= kin_d; s_q <= s_d; slot4_q <= slot4_d;
      mv_q <= mv_d; scale_q <= scale_d; prod_q <= prod_d; bnd_q <= bnd_d; np_q <= np_d;
      idx_q <= idx_d; grp_q <= grp_d; second_q <= second_d;
      hold_q <= hold_d; hold_valid_q <= hold_valid_d; out_q <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The held record is always flushed before a new request can be taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_valid_q) else $error("record held while idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx) else $error("scan index beyond table");

  a_second_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (state_q == S_SCAN && mode_q == M_EVENT))
    else $error("second crossing record outside event scan");

  a_last_only_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && out_d.last && !(out_valid_q && out_stall_i)) |-> state_q == S_FLUSH)
    else $error("last record issued outside flush");

endmodule
